@@ design/adc_config_and_auto_gain_core_defines.svh @@
// Assertion macros used by the gain-table module of the ADC auto-gain controller RTL.
`ifndef ADC_CONFIG_AND_AUTO_GAIN_CORE_DEFINES_SVH
`define ADC_CONFIG_AND_AUTO_GAIN_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ACAG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACAG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/acag_pkg.sv @@
// Types and constants of the ADC configuration and auto-gain controller.
`default_nettype none
package acag_pkg;

   localparam int CH_W    = 2;
   localparam int GAIN_W  = 3;
   localparam int RATE_W  = 3;
   localparam int MASK_W  = 4;
   localparam int LIM_W   = 16;
   localparam int SMP_W   = 16;
   localparam int CW_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [GAIN_W-1:0] GAIN_MAX   = 3'd5;
   localparam logic [LIM_W-1:0]  HIGH_RESET = 16'd26213;
   localparam logic [LIM_W-1:0]  LOW_RESET  = 16'd6553;

   // config word bit positions
   localparam int CW_START_BIT = 15;
   localparam int CW_SE_BIT    = 14;
   localparam int CW_CH_LSB    = 12;
   localparam int CW_GAIN_LSB  = 9;
   localparam int CW_SS_BIT    = 8;
   localparam int CW_RATE_LSB  = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RATE      = 3'd0,
      REG_CONT      = 3'd1,
      REG_DIFF      = 3'd2,
      REG_MASK      = 3'd3,
      REG_INIT_GAIN = 3'd4,
      REG_HIGH      = 3'd5,
      REG_LOW       = 3'd6
   } acag_reg_type;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_RESULT = 1'b1
   } acag_op_type;

   typedef enum logic {
      KIND_CONFIG = 1'b0,
      KIND_SAMPLE = 1'b1
   } acag_kind_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic              cont;
      logic              diff;
      logic [MASK_W-1:0] mask;
      logic [LIM_W-1:0]  high;
      logic [LIM_W-1:0]  low;
      logic              gain_load;
      logic [GAIN_W-1:0] gain_init;
   } acag_cfg_type;

   typedef struct packed {
      acag_op_type              opcode;
      logic [CH_W-1:0]          channel_select;
      logic signed [SMP_W-1:0]  conversion_value;
   } acag_item_type;

   typedef struct packed {
      acag_kind_type            result_kind;
      logic [CW_W-1:0]          config_word;
      logic signed [SMP_W-1:0]  sample_value;
      logic [CH_W-1:0]          sample_channel;
      logic [GAIN_W-1:0]        sample_gain;
   } acag_result_type;

endpackage
`default_nettype wire

@@ design/adc_config_and_auto_gain_core.sv @@
// Top level of the ADC configuration and auto-gain controller.
// Takes one word per clock cycle when the result side keeps up: a word goes into the input
// register, then the config word or sample result is formed from the gain table and the
// current channel and lands in the result register, which drives rsp_tvalid and holds the
// result until rsp_tready takes it. Gain stepping and the current-channel update take effect
// as the word moves into the result register, so the next word already sees them.
// Configuration writes take effect at the write edge; writing the initial gain (saturated
// to 5) reloads every channel gain.
`default_nettype none
module adc_config_and_auto_gain_core
   import acag_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [23:0]          req_tdata,  // channel_select[1:0], conversion_value[17:2]
   input  wire logic                 req_tuser,  // opcode
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [39:0]          rsp_tdata,  // config_word[15:0], sample_value[31:16],
                                                 // sample_channel[33:32], sample_gain[36:34]
   output      logic                 rsp_tuser,  // result_kind
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   acag_cfg_type    cfg;
   acag_item_type   s1_ff, s1_in;
   logic            s1_valid_ff, s1_valid_in;
   acag_result_type res;
   acag_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_ready;
   logic            fire;

   acag_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   acag_gain #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_gain (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (s1_ff),
      .fire   (fire),
      .result (res)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_in.opcode           = acag_op_type'(req_tuser);
         s1_in.channel_select   = req_tdata[1:0];
         s1_in.conversion_value = req_tdata[17:2];
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tdata  = {3'b000, rsp_ff.sample_gain, rsp_ff.sample_channel,
                        rsp_ff.sample_value, rsp_ff.config_word};

endmodule
`default_nettype wire

@@ design/acag_cfg.sv @@
// Configuration register file of the ADC auto-gain controller.
`default_nettype none
module acag_cfg
   import acag_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output acag_cfg_type              cfg
);

   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              cont_ff, cont_in;
   logic              diff_ff, diff_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [LIM_W-1:0]  high_ff, high_in;
   logic [LIM_W-1:0]  low_ff, low_in;
   logic [GAIN_W-1:0] wr_gain;

   always_comb begin
      rate_in = rate_ff;
      cont_in = cont_ff;
      diff_in = diff_ff;
      mask_in = mask_ff;
      high_in = high_ff;
      low_in  = low_ff;
      if (csr_we) begin
         case (acag_reg_type'(csr_index))
            REG_RATE: rate_in = csr_wdata[RATE_W-1:0];
            REG_CONT: cont_in = csr_wdata[0];
            REG_DIFF: diff_in = csr_wdata[0];
            REG_MASK: mask_in = csr_wdata[MASK_W-1:0];
            REG_HIGH: high_in = csr_wdata[LIM_W-1:0];
            REG_LOW:  low_in  = csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         cont_ff <= 1'b0;
         diff_ff <= 1'b0;
         mask_ff <= '0;
         high_ff <= HIGH_RESET;
         low_ff  <= LOW_RESET;
      end else begin
         rate_ff <= rate_in;
         cont_ff <= cont_in;
         diff_ff <= diff_in;
         mask_ff <= mask_in;
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

   // out-of-range initial gain saturates
   assign wr_gain = (csr_wdata[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : csr_wdata[GAIN_W-1:0];

   always_comb begin
      cfg.rate      = rate_ff;
      cfg.cont      = cont_ff;
      cfg.diff      = diff_ff;
      cfg.mask      = mask_ff;
      cfg.high      = high_ff;
      cfg.low       = low_ff;
      cfg.gain_load = csr_we && (acag_reg_type'(csr_index) == REG_INIT_GAIN);
      cfg.gain_init = wr_gain;
   end

endmodule
`default_nettype wire

@@ design/acag_gain.sv @@
// Channel gain table, current channel and per-word result logic.
`default_nettype none
`include "adc_config_and_auto_gain_core_defines.svh"
module acag_gain
   import acag_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
)(
   input  wire logic      clock,
   input  wire logic      reset,
   input  acag_cfg_type   cfg,
   input  acag_item_type  item,
   input  wire logic      fire,
   output acag_result_type result
);

   logic [GAIN_W-1:0] gain_ff [NUM_CHANNELS];
   logic [GAIN_W-1:0] gain_in [NUM_CHANNELS];
   logic [CH_W-1:0]   cur_ff, cur_in;
   logic [CH_W-1:0]   ch_sel;
   logic [CH_W-1:0]   rd_ch;
   logic [GAIN_W-1:0] gain_rd;
   logic [GAIN_W-1:0] gain_step;
   logic [SMP_W:0]    mag;
   logic [CW_W-1:0]   cw;

   always_comb begin
      ch_sel = item.channel_select;
      if ({1'b0, ch_sel} >= (CH_W+1)'(NUM_CHANNELS)) begin
         ch_sel = CH_W'(NUM_CHANNELS - 1);
      end
      rd_ch = (item.opcode == OP_START) ? ch_sel : cur_ff;
      gain_rd = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (rd_ch == CH_W'(i)) begin
            gain_rd = gain_ff[i];
         end
      end
   end

   // magnitude, most negative sample gives 32768
   always_comb begin
      if (item.conversion_value[SMP_W-1]) begin
         mag = (SMP_W+1)'(1 << SMP_W) - {1'b0, item.conversion_value};
      end else begin
         mag = {1'b0, item.conversion_value};
      end
      gain_step = gain_rd;
      if (cfg.mask[rd_ch]) begin
         if ((mag > {1'b0, cfg.high}) && (gain_rd != '0)) begin
            gain_step = gain_rd - 1'b1;
         end else if ((mag < {1'b0, cfg.low}) && (gain_rd < GAIN_MAX)) begin
            gain_step = gain_rd + 1'b1;
         end
      end
   end

   always_comb begin
      cw = '0;
      cw[CW_START_BIT] = !cfg.cont;
      cw[CW_SS_BIT]    = !cfg.cont;
      cw[CW_SE_BIT]    = !cfg.diff;
      cw[CW_CH_LSB +: CH_W]     = ch_sel;
      cw[CW_GAIN_LSB +: GAIN_W] = gain_rd;
      cw[CW_RATE_LSB +: RATE_W] = cfg.rate;
   end

   always_comb begin
      if (item.opcode == OP_START) begin
         result.result_kind    = KIND_CONFIG;
         result.config_word    = cw;
         result.sample_value   = '0;
         result.sample_channel = '0;
         result.sample_gain    = '0;
      end else begin
         result.result_kind    = KIND_SAMPLE;
         result.config_word    = '0;
         result.sample_value   = item.conversion_value;
         result.sample_channel = cur_ff;
         result.sample_gain    = gain_rd;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         gain_in[i] = gain_ff[i];
      end
      if (fire) begin
         if (item.opcode == OP_START) begin
            cur_in = ch_sel;
         end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (rd_ch == CH_W'(i)) begin
                  gain_in[i] = gain_step;
               end
            end
         end
      end
      if (cfg.gain_load) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            gain_in[i] = cfg.gain_init;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            gain_ff[i] <= '0;
         end
      end else begin
         cur_ff <= cur_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            gain_ff[i] <= gain_in[i];
         end
      end
   end

   `ACAG_ASSERT_IMP(a_cur_range, clock, reset, 1'b1, {1'b0, cur_ff} < (CH_W+1)'(NUM_CHANNELS), "current channel out of range")

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chk
      `ACAG_ASSERT_IMP(a_gain_range, clock, reset, 1'b1, gain_ff[g] <= GAIN_MAX, "gain code above maximum")
      `ACAG_ASSERT_NXT(a_gain_hold, clock, reset, !fire && !cfg.gain_load, $stable(gain_ff[g]), "gain changed without a word")
   end

   `ACAG_ASSERT_NXT(a_start_cur, clock, reset, fire && (item.opcode == OP_START), cur_ff == $past(ch_sel), "start word did not set current channel")

endmodule
`default_nettype wire

@@ tb/adc_config_and_auto_gain_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ADC configuration and auto-gain controller.
module adc_config_and_auto_gain_core_tb;
   import acag_pkg::*;

   localparam int NUM_CH      = 4;
   localparam int CYCLE_LIMIT = 150000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 4;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_WORDS = 105;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_wdata  = '0;

   adc_config_and_auto_gain_core #(.NUM_CHANNELS(NUM_CH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the controller
   logic [RATE_W-1:0] rate_code;
   logic              cont_mode;
   logic              diff_mode;
   logic [MASK_W-1:0] gain_mask;
   logic [LIM_W-1:0]  high_lim;
   logic [LIM_W-1:0]  low_lim;
   logic [GAIN_W-1:0] gain_table [NUM_CH];
   logic [CH_W-1:0]   active_channel;

   acag_item_type   words_to_send [$];
   acag_result_type results_due [$];
   acag_item_type   offered_word;

   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   logic        hold_arm = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic acag_result_type form_result(input acag_item_type w);
      acag_result_type r;
      logic [CH_W-1:0]   ch;
      logic [GAIN_W-1:0] g;
      logic [16:0]       mag;
      r = '0;
      if (w.opcode == OP_START) begin
         ch = w.channel_select;
         if (int'(ch) >= NUM_CH) ch = CH_W'(NUM_CH - 1);
         r.result_kind = KIND_CONFIG;
         r.config_word[CW_START_BIT] = ~cont_mode;
         r.config_word[CW_SS_BIT] = ~cont_mode;
         r.config_word[CW_SE_BIT] = ~diff_mode;
         r.config_word[CW_CH_LSB +: CH_W] = ch;
         r.config_word[CW_GAIN_LSB +: GAIN_W] = gain_table[ch];
         r.config_word[CW_RATE_LSB +: RATE_W] = rate_code;
         active_channel = ch;
      end else begin
         ch = active_channel;
         g = gain_table[ch];
         mag = w.conversion_value[SMP_W-1] ? 17'h10000 - {1'b0, w.conversion_value}
                                          : {1'b0, w.conversion_value};
         r.result_kind = KIND_SAMPLE;
         r.sample_value = w.conversion_value;
         r.sample_channel = ch;
         r.sample_gain = g;
         if (gain_mask[ch]) begin
            if (mag > high_lim && g > 0)
               gain_table[ch] = g - 1'b1;
            else if (mag < low_lim && g < GAIN_MAX)
               gain_table[ch] = g + 1'b1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 30) $display("ERROR @%0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) results_due.push_back(form_result(offered_word));
         if (!req_tvalid || req_tready) begin
            if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               offered_word = words_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, offered_word.conversion_value, offered_word.channel_select};
               req_tuser <= offered_word.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_arm) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      acag_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_kind    = acag_kind_type'(rsp_tuser);
         got.config_word    = rsp_tdata[15:0];
         got.sample_value   = rsp_tdata[31:16];
         got.sample_channel = rsp_tdata[33:32];
         got.sample_gain    = rsp_tdata[36:34];
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("result word with none due: %h/%b", rsp_tdata, rsp_tuser));
         end else begin
            want = results_due.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch($sformatf("kind exp %b got %b", want.result_kind,
                                         got.result_kind));
            if (got.config_word !== want.config_word)
               report_mismatch($sformatf("config word exp %h got %h", want.config_word,
                                         got.config_word));
            if (got.sample_value !== want.sample_value)
               report_mismatch($sformatf("sample exp %h got %h", want.sample_value,
                                         got.sample_value));
            if (got.sample_channel !== want.sample_channel)
               report_mismatch($sformatf("channel exp %0d got %0d", want.sample_channel,
                                         got.sample_channel));
            if (got.sample_gain !== want.sample_gain)
               report_mismatch($sformatf("gain exp %0d got %0d", want.sample_gain,
                                         got.sample_gain));
            if (rsp_tdata[39:37] !== 3'b000)
               report_mismatch($sformatf("padding bits set: %b", rsp_tdata[39:37]));
         end
      end
   end

   task automatic write_reg(input acag_reg_type idx, input logic [CSR_DAT_W-1:0] val);
      logic [GAIN_W-1:0] g;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_RATE: rate_code = val[RATE_W-1:0];
         REG_CONT: cont_mode = val[0];
         REG_DIFF: diff_mode = val[0];
         REG_MASK: gain_mask = val[MASK_W-1:0];
         REG_INIT_GAIN: begin
            g = val[GAIN_W-1:0];
            if (g > GAIN_MAX) g = GAIN_MAX;
            foreach (gain_table[i]) gain_table[i] = g;
         end
         REG_HIGH: high_lim = val;
         REG_LOW: low_lim = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] rate, cont, diff, mask, init, high, low);
      write_reg(REG_RATE, rate);
      write_reg(REG_CONT, cont);
      write_reg(REG_DIFF, diff);
      write_reg(REG_MASK, mask);
      write_reg(REG_INIT_GAIN, init);
      write_reg(REG_HIGH, high);
      write_reg(REG_LOW, low);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_start(input int ch);
      acag_item_type w;
      w.opcode = OP_START;
      w.channel_select = CH_W'(ch);
      w.conversion_value = SMP_W'($urandom);
      words_to_send.push_back(w);
   endtask

   task automatic push_sample(input logic [15:0] v);
      acag_item_type w;
      w.opcode = OP_RESULT;
      w.channel_select = CH_W'($urandom);
      w.conversion_value = v;
      words_to_send.push_back(w);
   endtask

   // wait for everything in flight to come back, then let the pipe settle
   task automatic drain;
      @(negedge clock);
      while (words_to_send.size() != 0 || req_tvalid || results_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(4))
         0: return 16'($urandom_range(32768));
         1: return 16'($urandom_range(65535));
         2: return 16'(26213 + $urandom_range(400) - 200);
         3: return 16'(6553 + $urandom_range(400) - 200);
         default: begin
            case ($urandom_range(2))
               0: return 16'd0;
               1: return 16'd32768;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      int m;
      case ($urandom_range(5))
         0, 1: return 16'($urandom);
         2: m = int'(high_lim) + $urandom_range(2) - 1;
         3: m = int'(low_lim) + $urandom_range(2) - 1;
         4: m = $urandom_range(300);
         default: begin
            case ($urandom_range(3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
      if (m > 32768) m = 32768;
      if (m < 0) m = 0;
      return $urandom_range(1) ? 16'(-m) : 16'(m);
   endfunction

   // mostly a start word followed by a few samples, sometimes loose samples
   task automatic push_random_words(input int count);
      int n, k;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) != 0) begin
            push_start($urandom_range(3));
            n++;
         end
         k = $urandom_range(4);
         repeat (k) push_sample(pick_sample());
         n += k;
      end
   endtask

   initial begin
      int tx_pct [RAND_PHASES];
      int rx_pct [RAND_PHASES];
      tx_pct = '{0, 69, 0, 28, 0, 69, 0, 28, 0};
      rx_pct = '{0, 0, 69, 28, 0, 0, 69, 28, 0};
      rate_code = '0;
      cont_mode = 1'b0;
      diff_mode = 1'b0;
      gain_mask = '0;
      high_lim = HIGH_RESET;
      low_lim = LOW_RESET;
      foreach (gain_table[i]) gain_table[i] = '0;
      active_channel = '0;

      wait (!reset);
      @(negedge clock);

      // reset settings
      push_start(2);
      push_sample(16'd1000);
      push_sample(16'h8000);
      push_start(3);
      push_sample(16'd0);
      drain();

      // gain walk over default limits, initial gain beyond range
      configure(16'd7, 16'd0, 16'd0, 16'hF, 16'd7, 16'd26213, 16'd6553);
      push_start(1);
      push_sample(16'h8000);
      push_sample(16'h7FFF);
      push_sample(16'd26213);
      push_sample(16'd26214);
      push_sample(16'(-26214));
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'd6553);
      push_sample(16'd6552);
      push_sample(16'd0);
      push_sample(16'hFFFF);
      push_start(0);
      push_sample(16'd1);
      push_start(3);
      drain();

      // high limit below low limit: step-down wins unless gain is 0
      configure(16'd0, 16'd1, 16'd1, 16'h1, 16'd0, 16'd100, 16'd1000);
      push_start(0);
      push_sample(16'd500);
      push_sample(16'd500);
      push_sample(16'(-500));
      push_start(1);
      push_sample(16'd0);
      drain();

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == 0)
            configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5, 16'hFFFF, 16'd32768);
         else if (p == 1)
            configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
         else
            configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), pick_limit(), pick_limit());
         tx_idle_pct = tx_pct[p];
         rx_stall_pct = rx_pct[p];
         push_random_words(PHASE_WORDS);
         if (p == 4) begin
            @(posedge clock);
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/acag_pkg.sv
design/acag_cfg.sv
design/acag_gain.sv
design/adc_config_and_auto_gain_core.sv
tb/adc_config_and_auto_gain_core_tb.sv
